### hdl/ffba_pkg.sv
`timescale 1ns / 1ps

package ffba_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_BLOCKS_DEF  = 64;
  localparam int unsigned META_BYTES_DEF  = 32;
  localparam int unsigned MAX_REQUEST_DEF = 100000000;

  localparam int unsigned SIZE_W   = 27;  // stored block size
  localparam int unsigned REQ_W    = 32;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned PROD_W   = REQ_W + CNT_W;
  localparam int unsigned BYTE_W   = 32;  // byte counters and heap limit
  localparam int unsigned META_W   = 12;  // metadata byte count output
  localparam int unsigned STATUS_W = 3;

  localparam logic [BYTE_W-1:0] HEAP_LIMIT_RST = 32'd16777216;

  typedef enum logic [1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_ZALLOC = 2'd1,
    MODE_FREE   = 2'd2,
    MODE_RESIZE = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_BAD_SIZE     = 3'd1,
    ST_NO_ROOM      = 3'd2,
    ST_BAD_HANDLE   = 3'd3,
    ST_ALREADY_FREE = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DECODE,
    S_SCAN,
    S_APPEND,
    S_RELEASE,
    S_FIN
  } state_e;

  // One table entry as held in the RAM
  typedef struct packed {
    logic              free;
    logic [SIZE_W-1:0] size;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

### hdl/first_fit_block_allocator.sv
// Size or handle errors, frees and resizes in place finish without a table walk; the first-fit
// walk reads one table entry per cycle through the table RAM's one read port.
// Throughput: one request at a time; the next input transfer is taken once the
// result is in the output register. Reset clears counters and sets limit (16 MiB), no sweep.
`timescale 1ns / 1ps

module first_fit_block_allocator #(
  parameter int unsigned MAX_BLOCKS  = ffba_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned META_BYTES  = ffba_pkg::META_BYTES_DEF,
  parameter int unsigned MAX_REQUEST = ffba_pkg::MAX_REQUEST_DEF,
  localparam int unsigned HandleW = $clog2(MAX_BLOCKS),
  localparam int unsigned CountW  = $clog2(MAX_BLOCKS + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration: heap limit
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ffba_pkg::BYTE_W-1:0]     cfg_data_i,
  // request channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      mode_i,
  input  logic [ffba_pkg::REQ_W-1:0]      req_size_i,
  input  logic [ffba_pkg::CNT_W-1:0]      elem_count_i,
  input  logic [HandleW-1:0]              handle_i,
  input  logic                            handle_valid_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ffba_pkg::STATUS_W-1:0]   status_o,
  output logic [HandleW-1:0]              out_handle_o,
  output logic [CountW-1:0]               free_block_count_o,
  output logic [ffba_pkg::BYTE_W-1:0]     free_byte_count_o,
  output logic [CountW-1:0]               block_count_o,
  output logic [ffba_pkg::BYTE_W-1:0]     block_byte_count_o,
  output logic [ffba_pkg::META_W-1:0]     meta_byte_count_o
);

  import ffba_pkg::*;

  localparam int unsigned HeapW = BYTE_W + 2;  // sum that cannot wrap
  localparam int unsigned MetaFullW = CountW + META_W;

  // Sequencer and request registers
  state_e              state_q, state_d;
  mode_e               mode_q, mode_d;
  logic [REQ_W-1:0]    req_q, req_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [HandleW-1:0]  h_q, h_d;
  logic                hv_q, hv_d;
  logic [PROD_W-1:0]   size_q, size_d;      // requested size, product for zeroed allocate
  logic [SIZE_W-1:0]   old_size_q, old_size_d;
  logic [CountW-1:0]   ptr_q, ptr_d;        // next entry to read during the walk
  logic                chk_q, chk_d;        // RAM data belongs to chk_idx_q
  logic [HandleW-1:0]  chk_idx_q, chk_idx_d;
  status_e             st_q, st_d;
  logic [HandleW-1:0]  oh_q, oh_d;

  // Allocator state
  logic [CountW-1:0]   used_q, used_d;
  logic [BYTE_W-1:0]   heap_q, heap_d;
  logic [CountW-1:0]   free_n_q, free_n_d;
  logic [BYTE_W-1:0]   free_b_q, free_b_d;
  logic [BYTE_W-1:0]   total_q, total_d;
  logic [BYTE_W-1:0]   limit_q;

  // Output register
  logic                out_valid_q, out_valid_d;
  status_e             o_status_q, o_status_d;
  logic [HandleW-1:0]  o_handle_q, o_handle_d;
  logic [CountW-1:0]   o_fbc_q, o_fbc_d;
  logic [BYTE_W-1:0]   o_fbytes_q, o_fbytes_d;
  logic [CountW-1:0]   o_bc_q, o_bc_d;
  logic [BYTE_W-1:0]   o_bbytes_q, o_bbytes_d;
  logic [META_W-1:0]   o_meta_q, o_meta_d;

  // Entry table
  logic                ram_we;
  logic [HandleW-1:0]  ram_waddr;
  entry_t              ram_wdata;
  logic [HandleW-1:0]  ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;
  entry_t              rd;

  // Shared datapath terms
  logic [PROD_W-1:0]   prod;
  logic [HeapW-1:0]    heap_need;
  logic [MetaFullW-1:0] meta_full;
  logic                is_alloc;
  logic                do_release;
  logic                size_bad;
  logic                h_bad;
  logic                fits;

  ffba_ram #(
    .Width (ENTRY_W),
    .Depth (MAX_BLOCKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd = entry_t'(ram_rdata);

  // 32 x 16 multiply, registered into size_q
  assign prod = PROD_W'(req_q) * PROD_W'(cnt_q);

  assign heap_need = HeapW'(heap_q) + HeapW'(size_q[SIZE_W-1:0]) + HeapW'(META_BYTES);
  assign meta_full = MetaFullW'(used_q) * MetaFullW'(META_BYTES);

  // Null resize behaves as a plain allocate
  assign is_alloc   = (mode_q == MODE_ALLOC) || (mode_q == MODE_ZALLOC) ||
                      ((mode_q == MODE_RESIZE) && !hv_q);
  assign do_release = (mode_q == MODE_RESIZE) && hv_q;

  // Zero is a legal size only for zeroed allocate
  assign size_bad = (size_q > PROD_W'(MAX_REQUEST)) ||
                    ((mode_q != MODE_ZALLOC) && (size_q == '0));
  assign h_bad    = CountW'(h_q) >= used_q;
  assign fits     = chk_q && rd.free && (size_q[SIZE_W-1:0] <= rd.size);

  assign ram_raddr = (state_q == S_SCAN) ? ptr_q[HandleW-1:0] : h_q;

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    req_d       = req_q;
    cnt_d       = cnt_q;
    h_d         = h_q;
    hv_d        = hv_q;
    size_d      = size_q;
    old_size_d  = old_size_q;
    ptr_d       = ptr_q;
    chk_d       = 1'b0;
    chk_idx_d   = chk_idx_q;
    st_d        = st_q;
    oh_d        = oh_q;
    used_d      = used_q;
    heap_d      = heap_q;
    free_n_d    = free_n_q;
    free_b_d    = free_b_q;
    total_d     = total_q;
    out_valid_d = out_valid_q && !out_ready_i;
    o_status_d  = o_status_q;
    o_handle_d  = o_handle_q;
    o_fbc_d     = o_fbc_q;
    o_fbytes_d  = o_fbytes_q;
    o_bc_d      = o_bc_q;
    o_bbytes_d  = o_bbytes_q;
    o_meta_d    = o_meta_q;
    ram_we      = 1'b0;
    ram_waddr   = h_q;
    ram_wdata   = '{free: 1'b1, size: old_size_q};
    in_ready_o  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          mode_d  = mode_e'(mode_i);
          req_d   = req_size_i;
          cnt_d   = elem_count_i;
          h_d     = handle_i;
          hv_d    = handle_valid_i;
          st_d    = ST_OK;
          oh_d    = '0;
          state_d = S_MUL;
        end
      end

      // size product registered; RAM reads the named handle
      S_MUL: begin
        size_d  = (mode_q == MODE_ZALLOC) ? prod : PROD_W'(req_q);
        state_d = S_DECODE;
      end

      S_DECODE: begin
        ptr_d   = '0;
        state_d = S_FIN;
        if (is_alloc) begin
          if (size_bad) begin
            st_d = ST_BAD_SIZE;
          end else begin
            state_d = S_SCAN;
          end
        end else if (mode_q == MODE_FREE) begin
          if (hv_q) begin
            if (h_bad) begin
              st_d = ST_BAD_HANDLE;
            end else if (rd.free) begin
              st_d = ST_ALREADY_FREE;
            end else begin
              ram_we    = 1'b1;
              ram_wdata = '{free: 1'b1, size: rd.size};
              free_n_d  = free_n_q + 1'b1;
              free_b_d  = free_b_q + BYTE_W'(rd.size);
            end
          end
        end else begin
          // resize of a live block
          if (size_bad) begin
            st_d = ST_BAD_SIZE;
          end else if (h_bad || rd.free) begin
            st_d = ST_BAD_HANDLE;
          end else if (rd.size >= size_q[SIZE_W-1:0]) begin
            oh_d = h_q;
          end else begin
            old_size_d = rd.size;
            state_d    = S_SCAN;
          end
        end
      end

      // one entry per cycle: read issued at ptr_q, checked the cycle after
      S_SCAN: begin
        if (fits) begin
          ram_we    = 1'b1;
          ram_waddr = chk_idx_q;
          ram_wdata = '{free: 1'b0, size: rd.size};
          free_n_d  = free_n_q - 1'b1;
          free_b_d  = free_b_q - BYTE_W'(rd.size);
          oh_d      = chk_idx_q;
          state_d   = do_release ? S_RELEASE : S_FIN;
        end else if (ptr_q < used_q) begin
          chk_d     = 1'b1;
          chk_idx_d = ptr_q[HandleW-1:0];
          ptr_d     = ptr_q + 1'b1;
        end else begin
          state_d = S_APPEND;
        end
      end

      S_APPEND: begin
        state_d = S_FIN;
        if ((used_q >= CountW'(MAX_BLOCKS)) || (heap_need > HeapW'(limit_q))) begin
          st_d = ST_NO_ROOM;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = used_q[HandleW-1:0];
          ram_wdata = '{free: 1'b0, size: size_q[SIZE_W-1:0]};
          oh_d      = used_q[HandleW-1:0];
          used_d    = used_q + 1'b1;
          heap_d    = heap_need[BYTE_W-1:0];
          total_d   = total_q + BYTE_W'(size_q[SIZE_W-1:0]);
          if (do_release) begin
            state_d = S_RELEASE;
          end
        end
      end

      // resize moved: old block goes back to the free list
      S_RELEASE: begin
        ram_we   = 1'b1;
        free_n_d = free_n_q + 1'b1;
        free_b_d = free_b_q + BYTE_W'(old_size_q);
        state_d  = S_FIN;
      end

      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          o_status_d  = st_q;
          o_handle_d  = oh_q;
          o_fbc_d     = free_n_q;
          o_fbytes_d  = free_b_q;
          o_bc_d      = used_q;
          o_bbytes_d  = total_q;
          o_meta_d    = meta_full[META_W-1:0];
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      chk_q       <= 1'b0;
      used_q      <= '0;
      heap_q      <= '0;
      free_n_q    <= '0;
      free_b_q    <= '0;
      total_q     <= '0;
      limit_q     <= HEAP_LIMIT_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      chk_q       <= chk_d;
      used_q      <= used_d;
      heap_q      <= heap_d;
      free_n_q    <= free_n_d;
      free_b_q    <= free_b_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    req_q      <= req_d;
    cnt_q      <= cnt_d;
    h_q        <= h_d;
    hv_q       <= hv_d;
    size_q     <= size_d;
    old_size_q <= old_size_d;
    ptr_q      <= ptr_d;
    chk_idx_q  <= chk_idx_d;
    st_q       <= st_d;
    oh_q       <= oh_d;
    o_status_q <= o_status_d;
    o_handle_q <= o_handle_d;
    o_fbc_q    <= o_fbc_d;
    o_fbytes_q <= o_fbytes_d;
    o_bc_q     <= o_bc_d;
    o_bbytes_q <= o_bbytes_d;
    o_meta_q   <= o_meta_d;
  end

  // Register writes are always taken
  assign cfg_ready_o        = 1'b1;
  assign out_valid_o        = out_valid_q;
  assign status_o           = o_status_q;
  assign out_handle_o       = o_handle_q;
  assign free_block_count_o = o_fbc_q;
  assign free_byte_count_o  = o_fbytes_q;
  assign block_count_o      = o_bc_q;
  assign block_byte_count_o = o_bbytes_q;
  assign meta_byte_count_o  = o_meta_q;

  // Free blocks are a subset of created blocks
  a_free_le_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_n_q <= used_q)
    else $error("free block count above block count");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CountW'(MAX_BLOCKS))
    else $error("block count above table depth");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (ptr_q <= used_q))
    else $error("walk pointer beyond created blocks");

  a_err_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (o_status_q != ST_OK)) |-> (o_handle_q == '0))
    else $error("handle returned with a failing status");

  a_load_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_FIN))
    else $error("result loaded outside the finish step");

endmodule

### hdl/ffba_ram.sv
`timescale 1ns / 1ps

module ffba_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
